>>> hdl/msh_pkg.sv
// ----------------------------------------------------------------------------
// Scatter histogram package
// Shared types, codes and defaults of the masked scatter histogram unit.
// ----------------------------------------------------------------------------
package msh_pkg;

   localparam int BINS_DEFAULT       = 65536;
   localparam int COUNT_BITS_DEFAULT = 32;
   localparam int VALUE_BITS_DEFAULT = 16;

   localparam int OUT_COUNT_BITS = 32;
   localparam int INDEX_BITS     = 16;
   localparam int ADDR_BITS      = 3;

   typedef enum logic [1:0] {
      OP_PIXEL = 2'd0,
      OP_COND  = 2'd1,
      OP_READ  = 2'd2,
      OP_CLEAR = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_DONE     = 2'd0,
      ST_NOT_MEMB = 2'd1,
      ST_NULL     = 2'd2,
      ST_RANGE    = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      REG_A_MIN   = 3'd0,
      REG_A_MAX   = 3'd1,
      REG_B_MIN   = 3'd2,
      REG_B_MAX   = 3'd3,
      REG_RAS_ON  = 3'd4,
      REG_PLOT_ON = 3'd5
   } reg_addr_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;   // latch the request fields
      logic mult;      // register products
      logic index;     // form bin index and range flags
      logic lookup;    // issue memory reads
      logic decide;    // evaluate result and write memories
      logic clear_we;  // clearing pass write
   } dp_cmd_type;

endpackage

>>> hdl/masked_scatter_histogram_unit.sv
// ----------------------------------------------------------------------------
// Masked scatter histogram unit
// Two-band scatter-plot accumulator with condition masking for one category.
// ----------------------------------------------------------------------------
// Sequence: start captures the request; the multiply, index, memory lookup
// and decide steps follow in the single sequencer, and the result registers
// load in the decide step. A new item is taken only when idle, after the last.
// Reset: a clearing pass zeroes every bin of both memories; busy is high
// until it finishes. The receiver cannot stall results.
module masked_scatter_histogram_unit #(
   parameter int BINS       = msh_pkg::BINS_DEFAULT,
   parameter int COUNT_BITS = msh_pkg::COUNT_BITS_DEFAULT,
   parameter int VALUE_BITS = msh_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [1:0]                           req_opcode,
   input  logic signed [VALUE_BITS-1:0]         req_band_a_value,
   input  logic signed [VALUE_BITS-1:0]         req_band_b_value,
   input  logic                                 req_band_a_null,
   input  logic                                 req_band_b_null,
   input  logic                                 req_raster_mark,
   input  logic [msh_pkg::INDEX_BITS-1:0]       req_bin_index,
   input  logic                                 req_cond_value,
   output logic                                 rsp_strobe,
   output logic                                 rsp_belongs,
   output logic [1:0]                           rsp_status,
   output logic [msh_pkg::OUT_COUNT_BITS-1:0]   rsp_bin_count,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [msh_pkg::ADDR_BITS+1:0]        paddr,
   input  logic [31:0]                          pwdata,
   output logic [31:0]                          prdata,
   output logic                                 pready
);
   import msh_pkg::*;

   logic signed [VALUE_BITS-1:0] a_min_ff, a_max_ff, b_min_ff, b_max_ff;
   logic                         ras_on_ff, plot_on_ff;
   logic                         wr;
   reg_addr_type                 ra;

   assign pready = 1'b1;
   assign wr     = psel && penable && pwrite;
   assign ra     = reg_addr_type'(paddr[ADDR_BITS+1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_min_ff   <= '0;
         a_max_ff   <= VALUE_BITS'(255);
         b_min_ff   <= '0;
         b_max_ff   <= VALUE_BITS'(255);
         ras_on_ff  <= 1'b0;
         plot_on_ff <= 1'b0;
      end else if (wr) begin
         unique case (ra)
            REG_A_MIN:   a_min_ff   <= pwdata[VALUE_BITS-1:0];
            REG_A_MAX:   a_max_ff   <= pwdata[VALUE_BITS-1:0];
            REG_B_MIN:   b_min_ff   <= pwdata[VALUE_BITS-1:0];
            REG_B_MAX:   b_max_ff   <= pwdata[VALUE_BITS-1:0];
            REG_RAS_ON:  ras_on_ff  <= pwdata[0];
            REG_PLOT_ON: plot_on_ff <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (ra)
         REG_A_MIN:   prdata = 32'(a_min_ff);
         REG_A_MAX:   prdata = 32'(a_max_ff);
         REG_B_MIN:   prdata = 32'(b_min_ff);
         REG_B_MAX:   prdata = 32'(b_max_ff);
         REG_RAS_ON:  prdata = {31'd0, ras_on_ff};
         REG_PLOT_ON: prdata = {31'd0, plot_on_ff};
         default:     prdata = '0;
      endcase
   end

   dp_cmd_type              cmd;
   logic                    clearing;
   logic [$clog2(BINS)-1:0] clear_addr;

   msh_ctrl #(.BINS(BINS)) u_ctrl (
      .clock, .reset, .start, .busy, .clearing, .clear_addr, .cmd
   );

   msh_dp #(.BINS(BINS), .COUNT_BITS(COUNT_BITS), .VALUE_BITS(VALUE_BITS)) u_dp (
      .clock, .reset, .cmd, .clear_addr,
      .a_min(a_min_ff), .a_max(a_max_ff), .b_min(b_min_ff), .b_max(b_max_ff),
      .ras_on(ras_on_ff), .plot_on(plot_on_ff),
      .opcode(req_opcode), .a_val(req_band_a_value), .b_val(req_band_b_value),
      .a_null(req_band_a_null), .b_null(req_band_b_null),
      .mark(req_raster_mark), .index(req_bin_index), .cond_val(req_cond_value),
      .valid(rsp_strobe), .belongs(rsp_belongs), .status(rsp_status),
      .count(rsp_bin_count)
   );

`ifndef NO_ASSERTIONS
   a_clear_busy: assert property (@(posedge clock) disable iff (reset)
      clearing |-> busy) else $error("clearing pass while not busy");
   a_strobe_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe) else $error("back to back result strobes");
   a_start_lat: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##5 rsp_strobe) else $error("result latency wrong");
   a_not_memb: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == ST_NOT_MEMB) |-> !rsp_belongs)
      else $error("not belonging yet belongs");
`endif

endmodule

>>> hdl/msh_ctrl.sv
// ----------------------------------------------------------------------------
// Scatter histogram controller
// Sequences the clearing pass after reset and the steps of one item.
// ----------------------------------------------------------------------------
module msh_ctrl #(
   parameter int BINS = msh_pkg::BINS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   output logic                clearing,
   output logic [$clog2(BINS)-1:0] clear_addr,
   output msh_pkg::dp_cmd_type cmd
);
   import msh_pkg::*;

   localparam int AW = $clog2(BINS);

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_MULT, S_INDEX, S_LOOKUP, S_DECIDE
   } state_type;

   state_type         state_ff;
   logic [AW-1:0]     clr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
      end else begin
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == AW'(BINS - 1)) state_ff <= S_IDLE;
            end
            S_IDLE:   if (start) state_ff <= S_MULT;
            S_MULT:   state_ff <= S_INDEX;
            S_INDEX:  state_ff <= S_LOOKUP;
            S_LOOKUP: state_ff <= S_DECIDE;
            S_DECIDE: state_ff <= S_IDLE;
            default:  state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy       = (state_ff != S_IDLE);
   assign clearing   = (state_ff == S_CLEAR);
   assign clear_addr = clr_ff;

   always_comb begin
      cmd          = '0;
      cmd.capture  = (state_ff == S_IDLE) && start;
      cmd.mult     = (state_ff == S_MULT);
      cmd.index    = (state_ff == S_INDEX);
      cmd.lookup   = (state_ff == S_LOOKUP);
      cmd.decide   = (state_ff == S_DECIDE);
      cmd.clear_we = (state_ff == S_CLEAR);
   end

endmodule

>>> hdl/msh_dp.sv
// ----------------------------------------------------------------------------
// Scatter histogram datapath
// Bin index arithmetic, condition and count memories, result register.
// ----------------------------------------------------------------------------
module msh_dp #(
   parameter int BINS       = msh_pkg::BINS_DEFAULT,
   parameter int COUNT_BITS = msh_pkg::COUNT_BITS_DEFAULT,
   parameter int VALUE_BITS = msh_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  msh_pkg::dp_cmd_type           cmd,
   input  logic [$clog2(BINS)-1:0]       clear_addr,
   input  logic signed [VALUE_BITS-1:0]  a_min,
   input  logic signed [VALUE_BITS-1:0]  a_max,
   input  logic signed [VALUE_BITS-1:0]  b_min,
   input  logic signed [VALUE_BITS-1:0]  b_max,
   input  logic                          ras_on,
   input  logic                          plot_on,
   input  logic [1:0]                    opcode,
   input  logic signed [VALUE_BITS-1:0]  a_val,
   input  logic signed [VALUE_BITS-1:0]  b_val,
   input  logic                          a_null,
   input  logic                          b_null,
   input  logic                          mark,
   input  logic [msh_pkg::INDEX_BITS-1:0] index,
   input  logic                          cond_val,
   output logic                          valid,
   output logic                          belongs,
   output logic [1:0]                    status,
   output logic [msh_pkg::OUT_COUNT_BITS-1:0] count
);
   import msh_pkg::*;

   localparam int AW = $clog2(BINS);
   localparam int DW = VALUE_BITS + 2;
   localparam int PW = 2 * DW;
   localparam logic [COUNT_BITS-1:0] CMAX = '1;

   logic [AW-1:0]  clr_addr;
   assign clr_addr = clear_addr;

   // Captured request.
   opcode_type                 op_ff;
   logic signed [DW-1:0]       da_ff, db_ff, sa_ff, sb_ff;
   logic                       nul_ff, mark_ff, cval_ff;
   logic [INDEX_BITS-1:0]      idx_in_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff     <= opcode_type'(opcode);
         da_ff     <= DW'(a_val) - DW'(a_min);
         db_ff     <= DW'(b_val) - DW'(b_min);
         sa_ff     <= DW'(a_max) - DW'(a_min) + DW'(1);
         sb_ff     <= DW'(b_max) - DW'(b_min) + DW'(1);
         nul_ff    <= a_null | b_null;
         mark_ff   <= mark;
         cval_ff   <= cond_val;
         idx_in_ff <= index;
      end
   end

   // Products, exact in PW bits.
   logic signed [PW-1:0] lim_ff, row_ff;
   logic signed [DW-1:0] da2_ff;
   always_ff @(posedge clock) begin
      if (cmd.mult) begin
         lim_ff <= PW'(sa_ff) * PW'(sb_ff);
         row_ff <= PW'(db_ff) * PW'(sa_ff);
         da2_ff <= da_ff;
      end
   end

   logic signed [PW:0] sum;
   assign sum = (PW+1)'(row_ff) + (PW+1)'(da2_ff);

   logic          inr_ff;
   logic [AW-1:0] pix_idx_ff;
   always_ff @(posedge clock) begin
      if (cmd.index) begin
         inr_ff <= !sum[PW] && (sum < (PW+1)'(lim_ff))
                   && (sum < (PW+1)'(BINS));
         pix_idx_ff <= AW'(sum);
      end
   end

   // Address selection for the item being processed.
   logic          op_inr;
   logic [AW-1:0] op_addr;
   assign op_inr  = (op_ff == OP_PIXEL) ? inr_ff :
                    ({{(32-INDEX_BITS){1'b0}}, idx_in_ff} < 32'(BINS));
   assign op_addr = (op_ff == OP_PIXEL) ? pix_idx_ff : AW'(idx_in_ff);

   logic                  cond_mem [BINS];
   logic [COUNT_BITS-1:0] cnt_mem  [BINS];
   logic                  cond_rd_ff;
   logic [COUNT_BITS-1:0] cnt_rd_ff;
   logic [AW-1:0]         addr_ff;

   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         cond_rd_ff <= cond_mem[op_addr];
         cnt_rd_ff  <= cnt_mem[op_addr];
         addr_ff    <= op_addr;
      end
   end

   logic                  bel;
   logic                  cnt_we, cond_we;
   logic [COUNT_BITS-1:0] cnt_new;
   status_type            st;
   logic [COUNT_BITS-1:0] cnt_out;

   always_comb begin
      bel     = 1'b0;
      cnt_we  = 1'b0;
      cond_we = 1'b0;
      st      = ST_DONE;
      cnt_new = (cnt_rd_ff == CMAX) ? cnt_rd_ff : cnt_rd_ff + 1'b1;
      cnt_out = '0;
      if (op_ff == OP_PIXEL) begin
         if (!ras_on && !plot_on) bel = 1'b1;
         else bel = (ras_on && mark_ff)
                    || (plot_on && !nul_ff && inr_ff && cond_rd_ff);
         priority if (!bel) st = ST_NOT_MEMB;
         else if (nul_ff)  st = ST_NULL;
         else if (!inr_ff) st = ST_RANGE;
         else begin
            cnt_we  = 1'b1;
            cnt_out = cnt_new;
         end
      end else if (!op_inr) begin
         st = ST_RANGE;
      end else begin
         unique case (op_ff)
            OP_COND:  cond_we = 1'b1;
            OP_READ:  cnt_out = cnt_rd_ff;
            OP_CLEAR: begin
               cnt_we  = 1'b1;
               cnt_new = '0;
            end
            default:  st = ST_DONE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clear_we) begin
         cond_mem[clr_addr] <= 1'b0;
         cnt_mem[clr_addr]  <= '0;
      end else if (cmd.decide) begin
         if (cond_we) cond_mem[addr_ff] <= cval_ff;
         if (cnt_we)  cnt_mem[addr_ff]  <= cnt_new;
      end
   end

   logic                      valid_ff, bel_ff;
   logic [1:0]                st_ff;
   logic [OUT_COUNT_BITS-1:0] cnt_ff;
   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= cmd.decide;
      if (cmd.decide) begin
         bel_ff <= bel;
         st_ff  <= st;
         cnt_ff <= OUT_COUNT_BITS'({{OUT_COUNT_BITS{1'b0}}, cnt_out});
      end
   end

   assign valid   = valid_ff;
   assign belongs = bel_ff;
   assign status  = st_ff;
   assign count   = cnt_ff;

endmodule
